// ===== sv/stc_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the scratchpad checker.
// No dependencies.
`default_nettype none
package stc_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned TempW   = 16;
  localparam int unsigned ResW    = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned OutW    = 24;

  localparam logic [DataW-1:0] CrcPoly     = 8'h8C;
  localparam logic [DataW-1:0] CfgLowMask  = 8'h1F;
  localparam logic [DataW-1:0] Byte7Marker = 8'h10;
  localparam logic [DataW-1:0] Byte6Reset  = 8'h0C;
  localparam logic [DataW-1:0] ByteOnes    = 8'hFF;
  localparam logic [DataW-1:0] ByteZero    = 8'h00;

  localparam logic [PosW-1:0] PosTempLo   = 4'd0;
  localparam logic [PosW-1:0] PosTempHi   = 4'd1;
  localparam logic [PosW-1:0] PosConfig   = 4'd4;
  localparam logic [PosW-1:0] PosReserved = 4'd5;
  localparam logic [PosW-1:0] PosMarker   = 4'd6;
  localparam logic [PosW-1:0] PosLastRsv  = 4'd7;

  // temperature limits in sixteenths of a degree
  localparam logic signed [TempW-1:0] RawMin = -16'sd880;
  localparam logic signed [TempW-1:0] RawMax = 16'sd2000;
  localparam logic signed [TempW-1:0] Raw85  = 16'sd1360;

  localparam logic [ResW-1:0] Res9  = 2'd0;
  localparam logic [ResW-1:0] Res10 = 2'd1;
  localparam logic [ResW-1:0] Res11 = 2'd2;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_ALL_ZERO  = 3'd1,
    ST_ALL_ONES  = 3'd2,
    ST_RSV_BAD   = 3'd3,
    ST_CRC_BAD   = 3'd4,
    ST_RANGE     = 3'd5,
    ST_STUCK     = 3'd6
  } status_t;

  typedef struct packed {
    logic             last;
    logic [DataW-1:0] crc;
    logic             seen_nonzero;
    logic             seen_not_ff;
    logic [DataW-1:0] temp_lo;
    logic [DataW-1:0] temp_hi;
    logic [DataW-1:0] cfg;
    logic             reserved_ok;
    logic             marker_seen;
  } frame_t;

  function automatic logic [DataW-1:0] crc8_byte(input logic [DataW-1:0] crc_in,
                                                 input logic [DataW-1:0] b);
    logic [DataW-1:0] c;
    logic             mix;
    c = crc_in;
    for (int k = 0; k < DataW; k++) begin
      mix = c[0] ^ b[k];
      c   = {1'b0, c[DataW-1:1]};
      if (mix) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/stc_frame_acc.sv =====
// Frame accumulator: byte position, running CRC and per-frame flags and bytes.
// Depends on stc_pkg.
`default_nettype none
module stc_frame_acc (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire,
  input  wire logic [stc_pkg::DataW-1:0] data_byte,
  output stc_pkg::frame_t                frame
);

  logic [stc_pkg::PosW-1:0]  pos_r, pos_nxt;
  logic [stc_pkg::DataW-1:0] crc_r, crc_nxt;
  logic                      nz_r, nz_nxt;
  logic                      nff_r, nff_nxt;
  logic [stc_pkg::DataW-1:0] lo_r, lo_nxt;
  logic [stc_pkg::DataW-1:0] hi_r, hi_nxt;
  logic [stc_pkg::DataW-1:0] cfg_r, cfg_nxt;
  logic                      rsv_r, rsv_nxt;
  logic                      mark_r, mark_nxt;
  logic                      last;

  assign last = pos_r[stc_pkg::PosW-1];

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    nz_nxt   = nz_r;
    nff_nxt  = nff_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    cfg_nxt  = cfg_r;
    rsv_nxt  = rsv_r;
    mark_nxt = mark_r;
    if (fire) begin
      if (last) begin
        pos_nxt  = '0;
        crc_nxt  = '0;
        nz_nxt   = 1'b0;
        nff_nxt  = 1'b0;
        lo_nxt   = '0;
        hi_nxt   = '0;
        cfg_nxt  = '0;
        rsv_nxt  = 1'b1;
        mark_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        crc_nxt = stc_pkg::crc8_byte(crc_r, data_byte);
        nz_nxt  = nz_r | (data_byte != stc_pkg::ByteZero);
        nff_nxt = nff_r | (data_byte != stc_pkg::ByteOnes);
        case (pos_r)
          stc_pkg::PosTempLo:   lo_nxt = data_byte;
          stc_pkg::PosTempHi:   hi_nxt = data_byte;
          stc_pkg::PosConfig:   cfg_nxt = data_byte;
          stc_pkg::PosReserved: rsv_nxt = rsv_r & (data_byte == stc_pkg::ByteOnes);
          stc_pkg::PosMarker:   mark_nxt = (data_byte == stc_pkg::Byte6Reset);
          stc_pkg::PosLastRsv:  rsv_nxt = rsv_r & (data_byte == stc_pkg::Byte7Marker);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= '0;
      nz_r   <= 1'b0;
      nff_r  <= 1'b0;
      lo_r   <= '0;
      hi_r   <= '0;
      cfg_r  <= '0;
      rsv_r  <= 1'b1;
      mark_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      nz_r   <= nz_nxt;
      nff_r  <= nff_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      cfg_r  <= cfg_nxt;
      rsv_r  <= rsv_nxt;
      mark_r <= mark_nxt;
    end
  end

  assign frame.last         = last;
  assign frame.crc          = crc_r;
  assign frame.seen_nonzero = nz_r;
  assign frame.seen_not_ff  = nff_r;
  assign frame.temp_lo      = lo_r;
  assign frame.temp_hi      = hi_r;
  assign frame.cfg          = cfg_r;
  assign frame.reserved_ok  = rsv_r;
  assign frame.marker_seen  = mark_r;

endmodule
`default_nettype wire

// ===== sv/stc_result.sv =====
// Final-byte checks and the result register toward the output channel.
// Depends on stc_pkg.
`default_nettype none
module stc_result (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire_last,
  input  wire logic [stc_pkg::DataW-1:0] data_byte,
  input  stc_pkg::frame_t                frame,
  input  wire logic                      out_tready,
  output logic                           out_tvalid,
  output logic [stc_pkg::OutW-1:0]       out_tdata
);

  logic                          out_valid_r;
  logic [stc_pkg::StatusW-1:0]   status_r;
  logic [stc_pkg::TempW-1:0]     temp_r;
  logic [stc_pkg::ResW-1:0]      res_r;

  logic [stc_pkg::ResW-1:0]      res;
  logic [stc_pkg::TempW-1:0]     raw;
  logic signed [stc_pkg::TempW-1:0] raw_s;
  stc_pkg::status_t              status;
  logic [stc_pkg::TempW-1:0]     temp_out;

  assign res = frame.cfg[6:5];

  always_comb begin
    raw = {frame.temp_hi, frame.temp_lo};
    case (res)
      stc_pkg::Res9:  raw = raw & 16'hFFF8;
      stc_pkg::Res10: raw = raw & 16'hFFFC;
      stc_pkg::Res11: raw = raw & 16'hFFFE;
      default: ;
    endcase
  end

  assign raw_s = $signed(raw);

  always_comb begin
    if (!(frame.seen_nonzero || (data_byte != stc_pkg::ByteZero))) begin
      status = stc_pkg::ST_ALL_ZERO;
    end else if (!(frame.seen_not_ff || (data_byte != stc_pkg::ByteOnes))) begin
      status = stc_pkg::ST_ALL_ONES;
    end else if (!frame.reserved_ok
                 || ((frame.cfg & stc_pkg::CfgLowMask) != stc_pkg::CfgLowMask)) begin
      status = stc_pkg::ST_RSV_BAD;
    end else if (frame.crc != data_byte) begin
      status = stc_pkg::ST_CRC_BAD;
    end else if ((raw_s < stc_pkg::RawMin) || (raw_s > stc_pkg::RawMax)) begin
      status = stc_pkg::ST_RANGE;
    end else if ((raw_s == stc_pkg::Raw85) && frame.marker_seen) begin
      status = stc_pkg::ST_STUCK;
    end else begin
      status = stc_pkg::ST_OK;
    end
  end

  always_comb begin
    case (status)
      stc_pkg::ST_ALL_ZERO,
      stc_pkg::ST_ALL_ONES,
      stc_pkg::ST_RSV_BAD,
      stc_pkg::ST_CRC_BAD: temp_out = '0;
      default:             temp_out = raw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) begin
      status_r <= status;
      temp_r   <= temp_out;
      res_r    <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(stc_pkg::OutW - stc_pkg::StatusW - stc_pkg::TempW - stc_pkg::ResW){1'b0}},
                       res_r, temp_r, status_r};

endmodule
`default_nettype wire

// ===== sv/temp_sensor_frame_checker.sv =====
// Top level of the temperature sensor scratchpad checker.
// Depends on stc_pkg, stc_frame_acc and stc_result.
//
// Feed the nine scratchpad bytes of one frame, byte 0 first, one item per
// cycle; the ninth byte produces one result item in the output register on
// the following cycle. The CRC-8 update of a byte is combinational, so the
// block sustains one byte per clock while in_tready stays high.
// Bytes 0 to 7 are taken even while a result waits; byte 8 waits only when the
// output register is full and not drained in the same cycle. After each result
// the block starts a fresh frame.
`default_nettype none
module temp_sensor_frame_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [stc_pkg::DataW-1:0] in_tdata,   // [7:0] data_byte
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [stc_pkg::OutW-1:0]       out_tdata   // [2:0] status, [18:3] temperature,
                                                     // [20:19] resolution, [23:21] zero
);

  stc_pkg::frame_t frame;
  logic            fire;
  logic            fire_last;

  assign in_tready = !(frame.last && out_tvalid && !out_tready);
  assign fire      = in_tvalid && in_tready;
  assign fire_last = fire && frame.last;

  stc_frame_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_tdata),
    .frame     (frame)
  );

  stc_result u_res (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire_last  (fire_last),
    .data_byte  (in_tdata),
    .frame      (frame),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== sv/stc_checker.sv =====
// Port-level checks for the scratchpad checker, bound to the top level.
// Depends on stc_pkg and temp_sensor_frame_checker.
`default_nettype none
module stc_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tvalid,
  input wire logic                      in_tready,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [stc_pkg::OutW-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= stc_pkg::ST_STUCK)
    else $error("undefined status code");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:21] == 3'd0)
    else $error("nonzero padding in result");

  a_early_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == stc_pkg::ST_ALL_ZERO ||
                   out_tdata[2:0] == stc_pkg::ST_ALL_ONES ||
                   out_tdata[2:0] == stc_pkg::ST_RSV_BAD ||
                   out_tdata[2:0] == stc_pkg::ST_CRC_BAD)
    |-> out_tdata[18:3] == 16'd0)
    else $error("temperature not cleared on early failure");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result item without an accepted byte");

endmodule

bind temp_sensor_frame_checker stc_checker u_stc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for temp_sensor_frame_checker: streams scratchpad frames
// byte by byte; checks readings against an in-bench predictor or a table row.
// Depends on stc_pkg and the temp_sensor_frame_checker RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    stc_pkg::status_t          status;
    logic [stc_pkg::TempW-1:0] temp;
    logic [stc_pkg::ResW-1:0]  res;
  } reading_t;

  typedef logic [8:0][stc_pkg::DataW-1:0] scratchpad_t;

  typedef enum logic [1:0] {
    CRC_GOOD,
    CRC_WRONG,
    CRC_AS_GIVEN
  } crc_mode_t;

  typedef struct packed {
    logic [stc_pkg::TempW-1:0] word;
    logic [stc_pkg::DataW-1:0] alarm_hi;
    logic [stc_pkg::DataW-1:0] alarm_lo;
    logic [stc_pkg::DataW-1:0] cfg;
    logic [stc_pkg::DataW-1:0] rsv5;
    logic [stc_pkg::DataW-1:0] marker;
    logic [stc_pkg::DataW-1:0] rsv7;
    logic [stc_pkg::DataW-1:0] crc;
    crc_mode_t                 mode;
    logic                      typed;
    reading_t                  want;
  } frame_row_t;

  localparam logic [stc_pkg::PosW-1:0] LastPos = 4'd8;
  localparam int NumRows = 16;
  localparam int RandomBytes = 2000;

  localparam frame_row_t DirRows [NumRows] = '{
    '{16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, CRC_AS_GIVEN, 1'b1,
      '{stc_pkg::ST_ALL_ZERO, 16'h0000, 2'd0}},
    '{16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, CRC_AS_GIVEN, 1'b1,
      '{stc_pkg::ST_ALL_ONES, 16'h0000, 2'd3}},
    '{16'h0191, 8'h4B, 8'h46, 8'hFF, 8'hFF, 8'h0C, 8'h10, 8'h00, CRC_GOOD, 1'b0,
      '{stc_pkg::ST_OK, 16'h0000, 2'd0}},
    '{16'h0191, 8'h4B, 8'h46, 8'h7F, 8'hFE, 8'h0C, 8'h10, 8'h00, CRC_GOOD, 1'b1,
      '{stc_pkg::ST_RSV_BAD, 16'h0000, 2'd3}},
    '{16'h0191, 8'h4B, 8'h46, 8'h1F, 8'hFF, 8'h0C, 8'h11, 8'h00, CRC_GOOD, 1'b1,
      '{stc_pkg::ST_RSV_BAD, 16'h0000, 2'd0}},
    '{16'h0191, 8'h4B, 8'h46, 8'h5E, 8'hFF, 8'h0C, 8'h10, 8'h00, CRC_GOOD, 1'b1,
      '{stc_pkg::ST_RSV_BAD, 16'h0000, 2'd2}},
    '{16'h0191, 8'h4B, 8'h46, 8'h3F, 8'hFF, 8'h0C, 8'h10, 8'h00, CRC_WRONG, 1'b1,
      '{stc_pkg::ST_CRC_BAD, 16'h0000, 2'd1}},
    '{16'h07D0, 8'h00, 8'hFF, 8'h7F, 8'hFF, 8'h00, 8'h10, 8'h00, CRC_GOOD, 1'b0,
      '{stc_pkg::ST_OK, 16'h0000, 2'd0}},
    '{16'hFC90, 8'hFF, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'h10, 8'h00, CRC_GOOD, 1'b0,
      '{stc_pkg::ST_OK, 16'h0000, 2'd0}},
    '{16'h07D1, 8'h55, 8'hAA, 8'h7F, 8'hFF, 8'h01, 8'h10, 8'h00, CRC_GOOD, 1'b1,
      '{stc_pkg::ST_RANGE, 16'h07D1, 2'd3}},
    '{16'hFC8F, 8'hAA, 8'h55, 8'h7F, 8'hFF, 8'h80, 8'h10, 8'h00, CRC_GOOD, 1'b1,
      '{stc_pkg::ST_RANGE, 16'hFC8F, 2'd3}},
    '{16'h7FFF, 8'h12, 8'h34, 8'h1F, 8'hFF, 8'h0C, 8'h10, 8'h00, CRC_GOOD, 1'b1,
      '{stc_pkg::ST_RANGE, 16'h7FF8, 2'd0}},
    '{16'h8000, 8'h01, 8'hFE, 8'h3F, 8'hFF, 8'h0C, 8'h10, 8'h00, CRC_GOOD, 1'b0,
      '{stc_pkg::ST_OK, 16'h0000, 2'd0}},
    '{16'h0557, 8'h4B, 8'h46, 8'h1F, 8'hFF, 8'h0C, 8'h10, 8'h00, CRC_GOOD, 1'b1,
      '{stc_pkg::ST_STUCK, 16'h0550, 2'd0}},
    '{16'h0550, 8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0D, 8'h10, 8'h00, CRC_GOOD, 1'b0,
      '{stc_pkg::ST_OK, 16'h0000, 2'd0}},
    '{16'h07D7, 8'h4B, 8'h46, 8'h9F, 8'hFF, 8'h0C, 8'h10, 8'h00, CRC_GOOD, 1'b0,
      '{stc_pkg::ST_OK, 16'h0000, 2'd0}}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [stc_pkg::DataW-1:0]     in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [stc_pkg::OutW-1:0]      out_tdata;

  logic [stc_pkg::PosW-1:0]      sp_pos;
  logic [stc_pkg::DataW-1:0]     sp_crc;
  logic                          sp_nonzero;
  logic                          sp_not_ones;
  logic [stc_pkg::DataW-1:0]     sp_tlo;
  logic [stc_pkg::DataW-1:0]     sp_thi;
  logic [stc_pkg::DataW-1:0]     sp_cfg;
  logic                          sp_rsv_good;
  logic                          sp_marker;

  reading_t             expected_readings [$];
  reading_t             head_reading;
  int unsigned          send_idle_pct;
  int unsigned          stall_pct;
  int unsigned          mismatches;
  int unsigned          readings_checked;
  int unsigned          bytes_sent;
  int unsigned          status_hits [7];

  temp_sensor_frame_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [stc_pkg::DataW-1:0] crc8_next(
      input logic [stc_pkg::DataW-1:0] acc, input logic [stc_pkg::DataW-1:0] d);
    logic [stc_pkg::DataW-1:0] a;
    a = acc;
    for (int i = 0; i < stc_pkg::DataW; i++) begin
      a = (a[0] ^ d[i]) ? ((a >> 1) ^ stc_pkg::CrcPoly) : (a >> 1);
    end
    return a;
  endfunction

  function automatic logic [stc_pkg::DataW-1:0] scratchpad_crc(input scratchpad_t f);
    logic [stc_pkg::DataW-1:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = crc8_next(c, f[k]);
    end
    return c;
  endfunction

  task automatic scratchpad_clear();
    sp_pos      = '0;
    sp_crc      = '0;
    sp_nonzero  = 1'b0;
    sp_not_ones = 1'b0;
    sp_tlo      = '0;
    sp_thi      = '0;
    sp_cfg      = '0;
    sp_rsv_good = 1'b1;
    sp_marker   = 1'b0;
  endtask

  task automatic scratchpad_step(input logic [stc_pkg::DataW-1:0] b, output bit done,
                                 output reading_t r);
    logic [stc_pkg::TempW-1:0] word;
    logic [stc_pkg::ResW-1:0]  res;
    stc_pkg::status_t          st;
    done = 1'b0;
    r    = '0;
    if (b != stc_pkg::ByteZero) sp_nonzero = 1'b1;
    if (b != stc_pkg::ByteOnes) sp_not_ones = 1'b1;
    if (sp_pos < LastPos) begin
      sp_crc = crc8_next(sp_crc, b);
      case (sp_pos)
        stc_pkg::PosTempLo:   sp_tlo = b;
        stc_pkg::PosTempHi:   sp_thi = b;
        stc_pkg::PosConfig:   sp_cfg = b;
        stc_pkg::PosReserved: if (b != stc_pkg::ByteOnes) sp_rsv_good = 1'b0;
        stc_pkg::PosMarker:   sp_marker = (b == stc_pkg::Byte6Reset);
        stc_pkg::PosLastRsv:  if (b != stc_pkg::Byte7Marker) sp_rsv_good = 1'b0;
        default: ;
      endcase
      sp_pos = sp_pos + 1'b1;
    end else begin
      res  = sp_cfg[6:5];
      word = {sp_thi, sp_tlo};
      case (res)
        stc_pkg::Res9:  word[2:0] = '0;
        stc_pkg::Res10: word[1:0] = '0;
        stc_pkg::Res11: word[0] = 1'b0;
        default: ;
      endcase
      if (!sp_nonzero) st = stc_pkg::ST_ALL_ZERO;
      else if (!sp_not_ones) st = stc_pkg::ST_ALL_ONES;
      else if (!sp_rsv_good || (sp_cfg & stc_pkg::CfgLowMask) != stc_pkg::CfgLowMask)
        st = stc_pkg::ST_RSV_BAD;
      else if (sp_crc != b) st = stc_pkg::ST_CRC_BAD;
      else if ($signed(word) < stc_pkg::RawMin || $signed(word) > stc_pkg::RawMax)
        st = stc_pkg::ST_RANGE;
      else if ($signed(word) == stc_pkg::Raw85 && sp_marker) st = stc_pkg::ST_STUCK;
      else st = stc_pkg::ST_OK;
      r.status = st;
      r.temp   = (st == stc_pkg::ST_OK || st == stc_pkg::ST_RANGE || st == stc_pkg::ST_STUCK)
                 ? word : '0;
      r.res    = res;
      done     = 1'b1;
      scratchpad_clear();
    end
  endtask

  // call at a falling edge; returns at the falling edge after the handshake
  task automatic push_byte(input logic [stc_pkg::DataW-1:0] b, input bit use_typed,
                           input reading_t typed);
    bit       done;
    reading_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scratchpad_step(b, done, r);
    if (done) expected_readings.push_back(use_typed ? typed : r);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_readings();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_readings.size() != 0) @(negedge clk);
  endtask

  function automatic scratchpad_t random_frame();
    scratchpad_t               f;
    logic [stc_pkg::TempW-1:0] w;
    int unsigned               kind;
    kind = $urandom_range(99);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: w = 16'($urandom_range(2880)) - 16'd880;
      6: w = 16'h0550 | 16'($urandom_range(7));
      7: w = 16'($urandom);
      8: begin
        case ($urandom_range(3))
          0: w = 16'h07D0;
          1: w = 16'h07D1;
          2: w = 16'hFC90;
          default: w = 16'hFC8F;
        endcase
      end
      default: w = 16'h0550;
    endcase
    f[0] = w[7:0];
    f[1] = w[15:8];
    f[2] = 8'($urandom);
    f[3] = 8'($urandom);
    f[4] = {1'($urandom), 2'($urandom), 5'h1F};
    f[5] = stc_pkg::ByteOnes;
    f[6] = $urandom_range(1) ? stc_pkg::Byte6Reset : 8'($urandom);
    f[7] = stc_pkg::Byte7Marker;
    f[8] = scratchpad_crc(f);
    if (kind < 75) begin
      if ($urandom_range(9) == 0) f[8] = f[8] ^ 8'($urandom_range(255, 1));
    end else if (kind < 85) begin
      f[$urandom_range(8)] = 8'($urandom);
    end else if (kind < 91) begin
      f = $urandom_range(1) ? '1 : '0;
      if ($urandom_range(1)) f[$urandom_range(8)] = 8'($urandom);
    end else begin
      for (int k = 0; k < 9; k++) f[k] = 8'($urandom);
    end
    return f;
  endfunction

  always @(negedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading, expected none, got 0x%06h", $time, out_tdata);
        mismatches++;
      end else begin
        head_reading = expected_readings.pop_front();
        if (out_tdata[2:0] !== head_reading.status) begin
          $display("%0t: status expected %0d got %0d", $time, head_reading.status,
                   out_tdata[2:0]);
          mismatches++;
        end
        if (out_tdata[18:3] !== head_reading.temp) begin
          $display("%0t: temperature expected 0x%04h got 0x%04h", $time, head_reading.temp,
                   out_tdata[18:3]);
          mismatches++;
        end
        if (out_tdata[20:19] !== head_reading.res) begin
          $display("%0t: resolution expected %0d got %0d", $time, head_reading.res,
                   out_tdata[20:19]);
          mismatches++;
        end
        if (out_tdata[23:21] !== 3'b000) begin
          $display("%0t: padding expected 0 got %0d", $time, out_tdata[23:21]);
          mismatches++;
        end
        status_hits[head_reading.status]++;
        readings_checked++;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("temp_sensor_frame_checker verification failed");
    $finish;
  end

  initial begin
    frame_row_t  row;
    scratchpad_t fb;
    int unsigned frames;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    out_tready       = 1'b1;
    send_idle_pct    = 0;
    stall_pct        = 0;
    mismatches       = 0;
    readings_checked = 0;
    bytes_sent       = 0;
    frames           = 0;
    foreach (status_hits[s]) status_hits[s] = 0;
    scratchpad_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumRows; i++) begin
      row   = DirRows[i];
      fb[0] = row.word[7:0];
      fb[1] = row.word[15:8];
      fb[2] = row.alarm_hi;
      fb[3] = row.alarm_lo;
      fb[4] = row.cfg;
      fb[5] = row.rsv5;
      fb[6] = row.marker;
      fb[7] = row.rsv7;
      case (row.mode)
        CRC_GOOD:  fb[8] = scratchpad_crc(fb);
        CRC_WRONG: fb[8] = scratchpad_crc(fb) ^ 8'h01;
        default:   fb[8] = row.crc;
      endcase
      for (int k = 0; k < 9; k++) push_byte(fb[k], row.typed && k == 8, row.want);
      frames++;
    end

    for (int phase = 0; phase < 4; phase++) begin
      drain_readings();
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      while (bytes_sent < NumRows * 9 + (phase + 1) * RandomBytes / 4) begin
        fb = random_frame();
        for (int k = 0; k < 9; k++) push_byte(fb[k], 1'b0, '0);
        frames++;
      end
    end

    drain_readings();
    stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("Streamed %0d bytes in %0d frames under four idle/stall mixes; %0d readings checked.",
             bytes_sent, frames, readings_checked);
    $display("Readings by status ok/zero/ones/reserved/crc/range/stuck: %0d %0d %0d %0d %0d %0d %0d",
             status_hits[stc_pkg::ST_OK], status_hits[stc_pkg::ST_ALL_ZERO],
             status_hits[stc_pkg::ST_ALL_ONES], status_hits[stc_pkg::ST_RSV_BAD],
             status_hits[stc_pkg::ST_CRC_BAD], status_hits[stc_pkg::ST_RANGE],
             status_hits[stc_pkg::ST_STUCK]);
    if (mismatches == 0) begin
      $display("temp_sensor_frame_checker verification clean");
    end else begin
      $display("temp_sensor_frame_checker verification failed");
    end
    $finish;
  end

endmodule
